// ----- design/kmee_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kmee_pkg;

    // default matrix size
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_row;    // write one row
        logic start_scan;  // latch per-row report mask, rewind row pointer
        logic open_row;    // take diff of current row into work bits
        logic next_row;    // advance row pointer
        logic push_event;  // send lowest pending key change
        logic push_empty;  // send empty end-of-scan result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any_report;  // some row will report on this scan
        logic row_report;  // row under pointer reports
        logic slot_free;   // output register can take a result
        logic work_last;   // lowest pending change is the last of the row
        logic rows_done;   // no reporting row left after this one
    } sts_t;

endpackage

`default_nettype wire

// ----- design/kmee_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmee_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           kind,
    output logic                in_stall,
    input  kmee_pkg::sts_t      sts,
    output kmee_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == kmee_pkg::KIND_LOAD)
                    begin
                        cmd.load_row = 1'b1;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next = sts.any_report ? ST_SEEK : ST_EMPTY;
                    end
                end
            end
            ST_SEEK:
            begin
                if (sts.row_report)
                begin
                    cmd.open_row = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.next_row = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.push_event = 1'b1;
                    if (sts.work_last)
                    begin
                        if (sts.rows_done)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.next_row = 1'b1;
                            state_next   = ST_SEEK;
                        end
                    end
                end
            end
            ST_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    cmd.push_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/kmee_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmee_dp
#(
    parameter int ROWS = kmee_pkg::ROWS_DEF,
    parameter int COLS = kmee_pkg::COLS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic [2:0]     row_index,
    input  wire logic [7:0]     row_bits,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic                event_valid,
    output logic [2:0]          event_row,
    output logic [2:0]          event_col,
    output logic                key_down,
    output logic                last,
    input  kmee_pkg::cmd_t      cmd,
    output kmee_pkg::sts_t      sts
);

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [COLS-1:0]  cur_reg [ROWS];
    logic [COLS-1:0]  rep_reg [ROWS];
    logic [ROWS-1:0]  report_reg;
    logic [ROWS-1:0]  report_now;
    logic [ROWS-1:0]  multi;
    logic [ROWS-1:0]  ghosted;
    logic [ROW_W-1:0] row_reg;
    logic [COLS-1:0]  work_reg;
    logic [COLS-1:0]  now_reg;
    logic [COLS-1:0]  work_rest;
    logic [COLS-1:0]  low_bit;
    logic [2:0]       low_col;
    logic             ghost_en_reg;
    logic             out_valid_reg;
    logic             event_valid_reg;
    logic [2:0]       event_row_reg;
    logic [2:0]       event_col_reg;
    logic             key_down_reg;
    logic             last_reg;
    logic             load_hit;

    // ghost check: a multi-key row sharing a column with another multi-key row
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            multi[r] = |(cur_reg[r] & (cur_reg[r] - COLS'(1)));
        end
        for (int r = 0; r < ROWS; r++)
        begin
            ghosted[r] = 1'b0;
            for (int o = 0; o < ROWS; o++)
            begin
                if (o != r && multi[o] && (|(cur_reg[r] & cur_reg[o])))
                begin
                    ghosted[r] = 1'b1;
                end
            end
            ghosted[r]    = ghosted[r] & multi[r];
            report_now[r] = (|(cur_reg[r] ^ rep_reg[r])) & ~(ghost_en_reg & ghosted[r]);
        end
    end

    // lowest pending change of the open row
    always_comb
    begin
        work_rest = work_reg & (work_reg - COLS'(1));
        low_bit   = work_reg & ~work_rest;
        low_col   = 3'd0;
        for (int c = COLS - 1; c >= 0; c--)
        begin
            if (work_reg[c])
            begin
                low_col = 3'(c);
            end
        end
    end

    assign load_hit = cmd.load_row && ({1'b0, row_index} < 4'(ROWS));

    assign sts.any_report = |report_now;
    assign sts.row_report = report_reg[row_reg];
    assign sts.slot_free  = !out_valid_reg || !out_stall;
    assign sts.work_last  = ~|work_rest;
    assign sts.rows_done  = ~|report_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                cur_reg[r] <= '0;
                rep_reg[r] <= '0;
            end
            report_reg    <= '0;
            row_reg       <= '0;
            ghost_en_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ghost_en_reg <= cfg_wdata;
            end
            if (load_hit)
            begin
                cur_reg[row_index[ROW_W-1:0]] <= row_bits[COLS-1:0];
            end
            if (cmd.start_scan)
            begin
                report_reg <= report_now;
                row_reg    <= '0;
            end
            if (cmd.open_row)
            begin
                rep_reg[row_reg]    <= cur_reg[row_reg];
                report_reg[row_reg] <= 1'b0;
            end
            if (cmd.next_row)
            begin
                row_reg <= ROW_W'(row_reg + 1'b1);
            end
            if (cmd.push_event || cmd.push_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.open_row)
        begin
            work_reg <= cur_reg[row_reg] ^ rep_reg[row_reg];
            now_reg  <= cur_reg[row_reg];
        end
        else if (cmd.push_event)
        begin
            work_reg <= work_rest;
        end
        if (cmd.push_event)
        begin
            event_valid_reg <= 1'b1;
            event_row_reg   <= 3'(row_reg);
            event_col_reg   <= low_col;
            key_down_reg    <= |(low_bit & now_reg);
            last_reg        <= (~|work_rest) && (~|report_reg);
        end
        else if (cmd.push_empty)
        begin
            event_valid_reg <= 1'b0;
            event_row_reg   <= 3'd0;
            event_col_reg   <= 3'd0;
            key_down_reg    <= 1'b0;
            last_reg        <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = event_valid_reg;
    assign event_row   = event_row_reg;
    assign event_col   = event_col_reg;
    assign key_down    = key_down_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ----- design/key_matrix_event_extractor.sv -----
// timing: a row load is written straight from idle; a scan-done transfer is captured,
//   then the rows are walked and each key event is sent, or an empty result if none reports
// throughput: loads back to back; the next transfer waits until the scan walk has ended,
//   the row walk and the events, one per cycle while the output is not stalled, set the wait
// reset: asynchronous active low; stored and reported rows clear to zero,
//   ghost check comes up enabled, output register empty
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_event_extractor
#(
    parameter int ROWS = kmee_pkg::ROWS_DEF,  // matrix rows, 1 to 8
    parameter int COLS = kmee_pkg::COLS_DEF   // matrix columns, 1 to 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: ghost check enable
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,

    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [2:0]  row_index,
    input  wire logic [7:0]  row_bits,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             event_valid,
    output logic [2:0]       event_row,
    output logic [2:0]       event_col,
    output logic             key_down,
    output logic             last
);

    // command and status bundles between the sequencer and the datapath
    kmee_pkg::cmd_t cmd;
    kmee_pkg::sts_t sts;

    // sequencer: idle takes transfers, a scan walks rows, then each changed key, or sends an empty result
    kmee_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: row store, reported store, ghost check, change picker and
    // the output register that decouples the result side
    kmee_dp
    #(
        .ROWS (ROWS),
        .COLS (COLS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .event_valid (event_valid),
        .event_row   (event_row),
        .event_col   (event_col),
        .key_down    (key_down),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
